### hdl/alsu_pkg.sv
// ---------------------------------------------------------------------------
// alsu_pkg: shared types and constants of the unscaled load/store unit
// Operation codes, register map, reset values and the data memory command.
// ---------------------------------------------------------------------------
package alsu_pkg;

  // default size of the data memory window in bytes
  localparam int unsigned MEM_BYTES_DEF = 4096;

  // register file geometry
  localparam int unsigned RF_DEPTH = 32;
  localparam int unsigned RF_AW    = 5;

  // configuration port
  localparam int unsigned APB_AW        = 4;
  localparam logic        REG_DATA_BASE = 1'b0;  // word select paddr[3]
  localparam logic [63:0] DATA_BASE_RST = 64'h0000_0000_1000_0000;

  // program counter advance per completed access
  localparam logic [63:0] PC_STEP = 64'd4;

  // operation codes; code 7 is unused
  typedef enum logic [2:0] {
    FN_STUR    = 3'd0,
    FN_STURB   = 3'd1,
    FN_STURH   = 3'd2,
    FN_LDUR    = 3'd3,
    FN_LDURB   = 3'd4,
    FN_LDURH   = 3'd5,
    FN_PRELOAD = 3'd6
  } func_t;

  // command from the address stage to the data memory
  typedef struct packed {
    logic       en;    // access this cycle
    logic       wr;    // store, else load
    logic [3:0] size;  // bytes accessed: 1, 2 or 8
  } dmem_cmd_t;

  // bytes touched by a load or store
  function automatic logic [3:0] access_size(logic [2:0] f);
    logic [3:0] sz;
    case (f)
      FN_STUR,  FN_LDUR:  sz = 4'd8;
      FN_STURB, FN_LDURB: sz = 4'd1;
      default:            sz = 4'd2;
    endcase
    return sz;
  endfunction

  // load or store (not preload, not the unused code)
  function automatic logic is_mem(logic [2:0] f);
    return f <= FN_LDURH;
  endfunction

  function automatic logic is_load(logic [2:0] f);
    return (f == FN_LDUR) || (f == FN_LDURB) || (f == FN_LDURH);
  endfunction

endpackage

### hdl/alsu_ifs.sv
// ---------------------------------------------------------------------------
// alsu_ifs: request and response channels of the load/store unit
// Valid/ready channels; a transaction moves when valid and ready are high.
// ---------------------------------------------------------------------------

// operation request
interface alsu_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [8:0] offset;
  logic [4:0]        base_index;
  logic [4:0]        data_index;
  logic [63:0]       preload_value;

  modport source (
    output valid, func, offset, base_index, data_index, preload_value,
    input  ready
  );
  modport sink (
    input  valid, func, offset, base_index, data_index, preload_value,
    output ready
  );
endinterface

// operation result
interface alsu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] loaded_value;
  logic [63:0] effective_address;
  logic        fault;

  modport source (
    output valid, loaded_value, effective_address, fault,
    input  ready
  );
  modport sink (
    input  valid, loaded_value, effective_address, fault,
    output ready
  );
endinterface

### hdl/alsu_rf.sv
// ---------------------------------------------------------------------------
// alsu_rf: 32 x 64 register file
// Two registered read ports, one write port. Valid bits make unwritten
// entries read as zero after reset; a write and a read of the same entry
// at one edge forward the new value.
// ---------------------------------------------------------------------------
module alsu_rf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [alsu_pkg::RF_AW-1:0] rd_addr_a,
  input  logic [alsu_pkg::RF_AW-1:0] rd_addr_b,
  output logic [63:0]                rd_data_a,
  output logic [63:0]                rd_data_b,
  input  logic                       wr_en,
  input  logic [alsu_pkg::RF_AW-1:0] wr_addr,
  input  logic [63:0]                wr_data
);

  logic [63:0]                    rf_mem [alsu_pkg::RF_DEPTH];
  logic [alsu_pkg::RF_DEPTH-1:0]  vld;
  logic [63:0]                    mem_a;
  logic [63:0]                    mem_b;
  logic                           hit_a;
  logic                           hit_b;
  logic                           byp_a;
  logic                           byp_b;
  logic [63:0]                    byp_data;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
  end

  // written-entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered reads with same-edge write forwarding
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_a    <= rf_mem[rd_addr_a];
      mem_b    <= rf_mem[rd_addr_b];
      hit_a    <= vld[rd_addr_a];
      hit_b    <= vld[rd_addr_b];
      byp_a    <= wr_en && (wr_addr == rd_addr_a);
      byp_b    <= wr_en && (wr_addr == rd_addr_b);
      byp_data <= wr_data;
    end
  end

  assign rd_data_a = byp_a ? byp_data : (hit_a ? mem_a : '0);
  assign rd_data_b = byp_b ? byp_data : (hit_b ? mem_b : '0);

endmodule

### hdl/alsu_dmem.sv
// ---------------------------------------------------------------------------
// alsu_dmem: byte-addressed data memory, eight byte banks
// Byte a sits in bank a mod 8, row a / 8, so any access of up to eight
// bytes touches each bank once. Read data is registered and returned
// zero-extended in access order. After reset all rows are cleared, one per
// cycle, while busy is high.
// ---------------------------------------------------------------------------
module alsu_dmem #(
  parameter  int unsigned MEM_BYTES = alsu_pkg::MEM_BYTES_DEF,
  localparam int unsigned REL_W     = $clog2(MEM_BYTES)
) (
  input  logic                clk,
  input  logic                rst,
  input  alsu_pkg::dmem_cmd_t cmd,
  input  logic [REL_W-1:0]    rel,
  input  logic [63:0]         wdata,
  output logic [63:0]         rdata,
  output logic                busy
);

  localparam int unsigned ROW_W = REL_W - 3;
  localparam int unsigned ROWS  = (MEM_BYTES + 7) / 8;

  logic [ROW_W-1:0] rel_row;
  logic [2:0]       rel_lo;
  logic             clr_busy;
  logic [ROW_W-1:0] clr_row;
  logic [7:0]       rbyte [8];
  logic [2:0]       lo_q;
  logic [3:0]       size_q;

  assign rel_row = rel[REL_W-1:3];
  assign rel_lo  = rel[2:0];
  assign busy    = clr_busy;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  // one bank per byte lane
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]       bank_mem [ROWS];
    logic [2:0]       lane;
    logic [ROW_W-1:0] row;
    logic             hit;

    // position of this bank's byte within the access, and its row
    assign lane = 3'(b) - rel_lo;
    assign row  = rel_row + {{(ROW_W - 1){1'b0}}, (3'(b) < rel_lo)};
    assign hit  = {1'b0, lane} < cmd.size;

    always_ff @(posedge clk) begin
      if (clr_busy) begin
        bank_mem[clr_row] <= '0;
      end else if (cmd.en && cmd.wr && hit) begin
        bank_mem[row] <= wdata[{lane, 3'b000} +: 8];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.en && !cmd.wr) begin
        rbyte[b] <= bank_mem[row];
      end
    end
  end

  // access shape kept for reassembly
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      lo_q   <= rel_lo;
      size_q <= cmd.size;
    end
  end

  // rotate banks back to access order, zero above the size
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic [2:0] idx;
      idx = lo_q + 3'(i);
      rdata[8*i +: 8] = (4'(i) < size_q) ? rbyte[idx] : 8'h00;
    end
  end

endmodule

### hdl/arm64_unscaled_load_store_unit.sv
// ---------------------------------------------------------------------------
// arm64_unscaled_load_store_unit: LDUR/STUR family load/store unit
// Top level: address stage, result stage, configuration and state.
// ---------------------------------------------------------------------------
// Each request executes one unscaled-offset load, store or register preload
// and gives exactly one response. The request is taken in the cycle the
// register file is read; the next cycle forms base plus offset, checks the
// data window and accesses the banked data memory; the write-back stage then
// writes the register file and loads the response register, stalling while
// the response register holds an untaken response. A new request is
// accepted when the write-back stage advances, with the write forwarded to its
// register reads; no request is accepted while one is in the address stage.
// After reset the data memory is cleared one 8-byte row per cycle, during
// which no request is accepted; configuration writes are taken at any time.
// data_base lies at APB address 0 (64-bit data).
module arm64_unscaled_load_store_unit #(
  parameter int unsigned MEM_BYTES = alsu_pkg::MEM_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [alsu_pkg::APB_AW-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  alsu_req_if.sink                    req,
  alsu_rsp_if.source                  rsp
);

  localparam int unsigned REL_W = $clog2(MEM_BYTES);

  // configuration and architectural state
  logic [63:0]                data_base;
  logic [63:0]                pc;

  // address stage
  logic                       s1_valid;
  logic [2:0]                 s1_func;
  logic [alsu_pkg::RF_AW-1:0] s1_rt;
  logic [63:0]                s1_pre;
  logic [63:0]                s1_offs;
  logic [63:0]                s1_koff;

  // write-back stage
  logic                       s2_valid;
  logic [2:0]                 s2_func;
  logic [alsu_pkg::RF_AW-1:0] s2_rt;
  logic [63:0]                s2_pre;
  logic [63:0]                s2_ea;
  logic                       s2_fault;

  // response register
  logic                       out_valid;
  logic [63:0]                out_loaded;
  logic [63:0]                out_ea;
  logic                       out_fault;

  logic                       accept;
  logic                       s2_adv;
  logic                       cfg_we;
  logic [63:0]                offs_sext;
  logic [63:0]                rf_a;
  logic [63:0]                rf_b;
  logic                       rf_we;
  logic [63:0]                rf_wd;
  logic [63:0]                ea;
  logic [63:0]                rel;
  logic [3:0]                 size;
  logic [REL_W:0]             rel_end;
  logic                       in_win;
  logic                       s1_mem;
  logic                       s2_load;
  alsu_pkg::dmem_cmd_t        dm_cmd;
  logic [63:0]                dm_rdata;
  logic                       dm_busy;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == alsu_pkg::REG_DATA_BASE) ? data_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= alsu_pkg::DATA_BASE_RST;
    end else if (cfg_we && (paddr[3] == alsu_pkg::REG_DATA_BASE)) begin
      data_base <= pwdata;
    end
  end

  // handshakes: one request in flight ahead of the write-back stage
  assign s2_adv    = s2_valid && (!out_valid || rsp.ready);
  assign req.ready = !dm_busy && !s1_valid && (!s2_valid || s2_adv);
  assign accept    = req.valid && req.ready;
  assign offs_sext = {{55{req.offset[8]}}, req.offset};

  // register file
  alsu_rf u_rf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (req.base_index),
    .rd_addr_b (req.data_index),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (rf_we),
    .wr_addr   (s2_rt),
    .wr_data   (rf_wd)
  );

  // request capture; offset minus window base is folded in early
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= req.func;
      s1_rt   <= req.data_index;
      s1_pre  <= req.preload_value;
      s1_offs <= offs_sext;
      s1_koff <= offs_sext - data_base;
    end
  end

  // address stage: effective address and window check
  assign ea      = rf_a + s1_offs;
  assign rel     = rf_a + s1_koff;
  assign size    = alsu_pkg::access_size(s1_func);
  assign rel_end = {1'b0, rel[REL_W-1:0]} + (REL_W + 1)'(size);
  assign in_win  = (rel < 64'(MEM_BYTES)) && (rel_end <= (REL_W + 1)'(MEM_BYTES));
  assign s1_mem  = alsu_pkg::is_mem(s1_func);

  assign dm_cmd.en   = s1_valid && s1_mem && in_win;
  assign dm_cmd.wr   = !alsu_pkg::is_load(s1_func);
  assign dm_cmd.size = size;

  alsu_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .cmd   (dm_cmd),
    .rel   (rel[REL_W-1:0]),
    .wdata (rf_b),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_func  <= s1_func;
      s2_rt    <= s1_rt;
      s2_pre   <= s1_pre;
      s2_ea    <= s1_mem ? ea : '0;
      s2_fault <= s1_mem && !in_win;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (s1_valid) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // write-back: load data or preload value into the data register
  assign s2_load = alsu_pkg::is_load(s2_func) && !s2_fault;
  assign rf_we   = s2_adv && ((s2_func == alsu_pkg::FN_PRELOAD) || s2_load);
  assign rf_wd   = (s2_func == alsu_pkg::FN_PRELOAD) ? s2_pre : dm_rdata;

  // program counter moves on every completed load or store that does not fault
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s2_adv && alsu_pkg::is_mem(s2_func) && !s2_fault) begin
      pc <= pc + alsu_pkg::PC_STEP;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_loaded <= s2_load ? dm_rdata : '0;
      out_ea     <= s2_ea;
      out_fault  <= s2_fault;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.loaded_value      = out_loaded;
  assign rsp.effective_address = out_ea;
  assign rsp.fault             = out_fault;

  // checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while the address stage is busy");

  a_no_access_clearing: assert property (@(posedge clk) disable iff (rst)
    dm_busy |-> !dm_cmd.en)
    else $error("data memory accessed during the clearing sweep");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_adv) |=> (s2_valid && $stable(s2_ea) && $stable(s2_fault)))
    else $error("stalled write-back stage lost its transaction");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s2_adv |=> rsp.valid)
    else $error("write-back produced no response");

endmodule

### sim/tb_arm64_unscaled_load_store_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_arm64_unscaled_load_store_unit: self-checking bench of the LDUR/STUR unit
// Drives load, store and preload operations over the request channel, keeps
// its own register file, data memory and window base, and checks every
// response field against the predicted value. Runs several window bases and
// request/response idle patterns.
// ---------------------------------------------------------------------------
module tb_arm64_unscaled_load_store_unit;

  localparam logic [2:0]  FN_UNUSED      = 3'd7;
  localparam logic [63:0] WIN_BYTES      = 64'(alsu_pkg::MEM_BYTES_DEF);
  localparam logic [3:0]  ADDR_DATA_BASE = {alsu_pkg::REG_DATA_BASE, 3'b000};
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned OPS_PER_PHASE  = 265;
  localparam int unsigned MAX_PRINTS     = 200;

  typedef struct packed {
    logic [2:0]  func;
    logic [8:0]  offset;
    logic [4:0]  base_index;
    logic [4:0]  data_index;
    logic [63:0] preload_value;
  } ldst_op_t;

  typedef struct packed {
    logic [63:0] loaded_value;
    logic [63:0] effective_address;
    logic        fault;
  } ldst_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  alsu_req_if req_ch();
  alsu_rsp_if rsp_ch();

  arm64_unscaled_load_store_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // architectural state as the bench expects it
  logic [63:0] model_regs [32];
  logic [7:0]  model_mem  [alsu_pkg::MEM_BYTES_DEF];
  logic [63:0] model_pc;
  logic [63:0] model_base;

  ldst_op_t     pending_ops [$];
  ldst_result_t expected_results [$];
  ldst_op_t     cur_op;
  ldst_result_t seen;
  ldst_result_t want;

  // registers the generator believes hold an address near the window
  bit          near_ptr [32];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // execute one operation on the bench state, return its response
  function automatic ldst_result_t execute_op(ldst_op_t op);
    ldst_result_t r;
    logic [63:0]  ea;
    logic [63:0]  rel;
    logic [63:0]  val;
    logic [63:0]  sz;
    int           i;
    r = '0;
    if (op.func == alsu_pkg::FN_PRELOAD) begin
      model_regs[op.data_index] = op.preload_value;
      return r;
    end
    if (op.func > alsu_pkg::FN_LDURH) return r;
    case (op.func)
      alsu_pkg::FN_STUR, alsu_pkg::FN_LDUR:   sz = 64'd8;
      alsu_pkg::FN_STURB, alsu_pkg::FN_LDURB: sz = 64'd1;
      default:                                sz = 64'd2;
    endcase
    ea  = model_regs[op.base_index] + {{55{op.offset[8]}}, op.offset};
    rel = ea - model_base;
    r.effective_address = ea;
    // every accessed byte must fall inside the window
    if (rel >= WIN_BYTES || sz > WIN_BYTES - rel) begin
      r.fault = 1'b1;
      return r;
    end
    if (op.func >= alsu_pkg::FN_LDUR) begin
      val = '0;
      for (i = 0; i < int'(sz); i++)
        val |= 64'(model_mem[int'(rel) + i]) << (8 * i);
      model_regs[op.data_index] = val;
      r.loaded_value = val;
    end else begin
      val = model_regs[op.data_index];
      for (i = 0; i < int'(sz); i++)
        model_mem[int'(rel) + i] = val[8*i +: 8];
    end
    model_pc = model_pc + alsu_pkg::PC_STEP;
    return r;
  endfunction

  function automatic ldst_op_t make_op(logic [2:0] f, logic [8:0] off, logic [4:0] rn,
                                       logic [4:0] rt, logic [63:0] val);
    ldst_op_t op;
    op.func          = f;
    op.offset        = off;
    op.base_index    = rn;
    op.data_index    = rt;
    op.preload_value = val;
    return op;
  endfunction

  // an address in or just around the current window
  function automatic logic [63:0] near_addr();
    case ($urandom_range(0, 3))
      0, 1:    return model_base + 64'(256 + $urandom_range(0, 127));
      2:       return model_base + WIN_BYTES - 64'($urandom_range(0, 300));
      default: return model_base + 64'($urandom_range(0, 4095 + 256)) - 64'd256;
    endcase
  endfunction

  function automatic ldst_op_t random_op();
    ldst_op_t    op;
    int unsigned k;
    int          r;
    logic [4:0]  ptrs [$];
    op.func       = 3'($urandom_range(0, 5));
    op.offset     = $urandom_range(0, 1) ? 9'($urandom_range(0, 31) - 16)
                                         : 9'($urandom_range(0, 511));
    op.base_index = 5'($urandom_range(0, 31));
    op.data_index = 5'($urandom_range(0, 31));
    op.preload_value = {$urandom, $urandom};
    k = $urandom_range(0, 99);
    if (k == 0) begin
      op.func = FN_UNUSED;
    end else if (k < 16) begin
      op.func = alsu_pkg::FN_PRELOAD;
      if ($urandom_range(0, 9) < 6) begin
        op.preload_value = near_addr();
        near_ptr[op.data_index] = 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0:       op.preload_value = '0;
          1:       op.preload_value = '1;
          default: ;
        endcase
        near_ptr[op.data_index] = 1'b0;
      end
    end else begin
      for (r = 0; r < 32; r++)
        if (near_ptr[r]) ptrs.push_back(5'(r));
      if (ptrs.size() != 0 && $urandom_range(0, 99) < 85)
        op.base_index = ptrs[$urandom_range(0, ptrs.size() - 1)];
      if (op.func >= alsu_pkg::FN_LDUR) near_ptr[op.data_index] = 1'b0;
    end
    return op;
  endfunction

  task automatic queue_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) pending_ops.push_back(random_op());
  endtask

  // nothing queued, nothing on the channel, nothing outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0);
  endtask

  task automatic write_data_base(input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DATA_BASE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_base = value;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (mismatch_count < MAX_PRINTS)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
    mismatch_count++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_results.push_back(execute_op(cur_op));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_op = pending_ops.pop_front();
          req_ch.func          <= cur_op.func;
          req_ch.offset        <= cur_op.offset;
          req_ch.base_index    <= cur_op.base_index;
          req_ch.data_index    <= cur_op.data_index;
          req_ch.preload_value <= cur_op.preload_value;
          req_ch.valid         <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.loaded_value      = rsp_ch.loaded_value;
        seen.effective_address = rsp_ch.effective_address;
        seen.fault             = rsp_ch.fault;
        if (expected_results.size() == 0) begin
          report_mismatch("transaction with none expected", seen.effective_address, '0);
        end else begin
          want = expected_results.pop_front();
          if (seen.loaded_value !== want.loaded_value)
            report_mismatch("loaded_value", seen.loaded_value, want.loaded_value);
          if (seen.effective_address !== want.effective_address)
            report_mismatch("effective_address", seen.effective_address,
                            want.effective_address);
          if (seen.fault !== want.fault)
            report_mismatch("fault", 64'(seen.fault), 64'(want.fault));
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // stimulus sequence
  initial begin
    logic [63:0] bases      [NUM_PHASES];
    int unsigned send_idle  [NUM_PHASES];
    int unsigned recv_stall [NUM_PHASES];
    int unsigned p;
    int          r;
    logic [63:0] b;

    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_ch.valid         = 1'b0;
    req_ch.func          = '0;
    req_ch.offset        = '0;
    req_ch.base_index    = '0;
    req_ch.data_index    = '0;
    req_ch.preload_value = '0;
    rsp_ch.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    mismatch_count       = 0;
    cycle_count          = 0;
    for (r = 0; r < 32; r++) model_regs[r] = '0;
    for (r = 0; r < int'(alsu_pkg::MEM_BYTES_DEF); r++) model_mem[r] = '0;
    model_pc   = '0;
    model_base = alsu_pkg::DATA_BASE_RST;

    bases[0] = alsu_pkg::DATA_BASE_RST; send_idle[0] = 0;  recv_stall[0] = 0;
    bases[1] = 64'h0;                  send_idle[1] = 80; recv_stall[1] = 0;
    bases[2] = '1;                     send_idle[2] = 0;  recv_stall[2] = 80;
    bases[3] = 64'hFFFF_FFFF_FFFF_F000; send_idle[3] = 17; recv_stall[3] = 17;
    bases[4] = {$urandom, $urandom};   send_idle[4] = 0;  recv_stall[4] = 0;
    bases[5] = 64'h7FFF_FFFF_FFFF_FC00; send_idle[5] = 0;  recv_stall[5] = 80;
    bases[6] = alsu_pkg::DATA_BASE_RST; send_idle[6] = 17; recv_stall[6] = 17;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        write_data_base(bases[p]);
      end
      @(negedge clk);
      send_idle_pct  = send_idle[p];
      recv_stall_pct = recv_stall[p];
      for (r = 0; r < 32; r++) near_ptr[r] = 1'b0;

      if (p == 0) begin
        b = alsu_pkg::DATA_BASE_RST;
        // round trip, partial stores, offset extremes, window edges, wrap
        pending_ops.push_back(make_op(alsu_pkg::FN_PRELOAD, 9'h000, 5'd0, 5'd0, b));
        pending_ops.push_back(make_op(alsu_pkg::FN_PRELOAD, 9'h000, 5'd0, 5'd31, '1));
        pending_ops.push_back(make_op(alsu_pkg::FN_PRELOAD, 9'h000, 5'd0, 5'd1,
                                      64'h0123_4567_89AB_CDEF));
        pending_ops.push_back(make_op(alsu_pkg::FN_STUR,  9'h000, 5'd0, 5'd1, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDUR,  9'h000, 5'd0, 5'd2, '1));
        pending_ops.push_back(make_op(alsu_pkg::FN_STUR,  9'h008, 5'd0, 5'd1, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_STURB, 9'h009, 5'd0, 5'd31, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_STURH, 9'h00C, 5'd0, 5'd31, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDUR,  9'h008, 5'd0, 5'd3, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDURB, 9'h001, 5'd0, 5'd4, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDURH, 9'h006, 5'd0, 5'd5, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_PRELOAD, 9'h1FF, 5'd31, 5'd6,
                                      b + 64'd256));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDUR,  9'h100, 5'd6, 5'd7, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_STUR,  9'h0FF, 5'd0, 5'd31, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDURH, 9'h0FF, 5'd0, 5'd8, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDUR,  9'h1FF, 5'd0, 5'd9, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_PRELOAD, 9'h000, 5'd0, 5'd10,
                                      b + WIN_BYTES - 64'd8));
        pending_ops.push_back(make_op(alsu_pkg::FN_STUR,  9'h000, 5'd10, 5'd1, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_STUR,  9'h001, 5'd10, 5'd1, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_STURB, 9'h007, 5'd10, 5'd31, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDURH, 9'h007, 5'd10, 5'd11, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDUR,  9'h001, 5'd31, 5'd31, '0));
        pending_ops.push_back(make_op(FN_UNUSED, 9'h1FF, 5'd31, 5'd31, '1));
        pending_ops.push_back(make_op(alsu_pkg::FN_LDUR,  9'h000, 5'd0, 5'd0, '0));
        pending_ops.push_back(make_op(alsu_pkg::FN_PRELOAD, 9'h000, 5'd0, 5'd12, '0));
      end

      // hold back the second half until the unit has fully drained
      queue_random(OPS_PER_PHASE / 2);
      wait_drained();
      queue_random(OPS_PER_PHASE - OPS_PER_PHASE / 2);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
